### rtl/bpa_pkg.sv
// Shared types, command codes and defaults of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int FRAMES_DEF          = 4096;
   localparam int MAX_ORDER_LEVEL_DEF = 10;
   localparam int PAGE_SHIFT_DEF      = 12;

   // Result status codes
   localparam logic [1:0] ST_ALLOC = 2'd0;
   localparam logic [1:0] ST_FREED = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BIG   = 2'd3;

   // Datapath commands
   typedef logic [4:0] cmd_type;
   localparam cmd_type CMD_NOP       = 5'd0;
   localparam cmd_type CMD_INIT_STEP = 5'd1;
   localparam cmd_type CMD_LOAD      = 5'd2;
   localparam cmd_type CMD_WANT_STEP = 5'd3;
   localparam cmd_type CMD_SRC_STEP  = 5'd4;
   localparam cmd_type CMD_RD_TGT    = 5'd5;
   localparam cmd_type CMD_UL_CAP    = 5'd6;
   localparam cmd_type CMD_UL_PRD    = 5'd7;
   localparam cmd_type CMD_UL_PWR    = 5'd8;
   localparam cmd_type CMD_UL_NRD    = 5'd9;
   localparam cmd_type CMD_UL_NWR    = 5'd10;
   localparam cmd_type CMD_UL_FWR    = 5'd11;
   localparam cmd_type CMD_SPLIT     = 5'd12;
   localparam cmd_type CMD_PUSH_F    = 5'd13;
   localparam cmd_type CMD_PUSH_HRD  = 5'd14;
   localparam cmd_type CMD_PUSH_HWR  = 5'd15;
   localparam cmd_type CMD_FIX_RD    = 5'd16;
   localparam cmd_type CMD_FIX_WR    = 5'd17;
   localparam cmd_type CMD_FREE_RD   = 5'd18;
   localparam cmd_type CMD_FREE_MARK = 5'd19;
   localparam cmd_type CMD_MRG_RD    = 5'd20;
   localparam cmd_type CMD_MRG_END   = 5'd21;
   localparam cmd_type CMD_RES_OVER  = 5'd22;
   localparam cmd_type CMD_RES_EMPTY = 5'd23;
   localparam cmd_type CMD_RES_OOR   = 5'd24;
   localparam cmd_type CMD_RES_DBL   = 5'd25;
   localparam cmd_type CMD_OUT       = 5'd26;

   typedef struct packed {
      logic init_done;
      logic op;
      logic want_done;
      logic want_over;
      logic src_done;
      logic src_over;
      logic idx_oor;
      logic rd_free;
      logic rd_code_big;
      logic rd_prev_none;
      logic rd_next_none;
      logic ul_next_none;
      logic split_more;
      logic buddy_in;
      logic push_h_none;
      logic mrg_stop;
      logic mrg_ok;
      logic out_busy;
   } stat_type;

endpackage

### rtl/bpa_datapath.sv
// Datapath of the buddy page allocator: frame memory, list heads, work registers.
`timescale 1ns / 1ps
module bpa_datapath #(
   parameter int FRAMES          = bpa_pkg::FRAMES_DEF,
   parameter int MAX_ORDER_LEVEL = bpa_pkg::MAX_ORDER_LEVEL_DEF,
   parameter int PAGE_SHIFT      = bpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bpa_pkg::cmd_type  cmd,
   output bpa_pkg::stat_type stat,
   input  logic              req_op,
   input  logic [31:0]       req_bytes,
   input  logic [11:0]       req_free_frame,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_frame_index,
   output logic [3:0]        rsp_block_order,
   output logic [1:0]        rsp_status
);
   import bpa_pkg::*;

   localparam int AW = $clog2(FRAMES);
   localparam int FW = $clog2(FRAMES + 1);
   localparam int OW = $clog2(MAX_ORDER_LEVEL + 2);
   localparam int HW = $clog2(MAX_ORDER_LEVEL + 1);
   localparam int WW = 2 * FW + OW + 1;
   localparam logic [FW-1:0] NONE     = FW'(FRAMES);
   localparam logic [OW-1:0] INTERIOR = OW'(MAX_ORDER_LEVEL + 1);
   localparam logic [OW-1:0] MAXO     = OW'(MAX_ORDER_LEVEL);
   localparam logic [31:0]   FRAMES_U = 32'(FRAMES);

   // word: {code, free, next, prev}
   logic [WW-1:0] frame_mem [FRAMES];
   logic [WW-1:0] rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [WW-1:0] mem_wdata;

   logic [OW-1:0] rd_code;
   logic          rd_free;
   logic [FW-1:0] rd_next, rd_prev;

   logic          op_ff, op_in;
   logic [31:0]   sh_ff, sh_in;
   logic [11:0]   idx_ff, idx_in;
   logic [OW-1:0] want_ff, want_in, src_ff, src_in, val_ff, val_in, tord_ff, tord_in;
   logic [AW-1:0] cur_ff, cur_in, tgt_ff, tgt_in;
   logic [FW-1:0] h_ff, h_in, ulp_ff, ulp_in, uln_ff, uln_in;
   logic [OW-1:0] ulc_ff, ulc_in;
   logic [FW-1:0] head_ff [MAX_ORDER_LEVEL+1];
   logic [FW-1:0] head_in [MAX_ORDER_LEVEL+1];
   logic [FW-1:0] initf_ff, initf_in;
   logic [OW-1:0] inito_ff, inito_in;
   logic [11:0]   resf_ff, resf_in, rspf_ff, rspf_in;
   logic [3:0]    reso_ff, reso_in, rspo_ff, rspo_in;
   logic [1:0]    ress_ff, ress_in, rsps_ff, rsps_in;
   logic          rspv_ff, rspv_in;

   logic [31:0]   idx32, cur32, init_f32, size32, mask32, end32, start32;
   logic [31:0]   sbuddy32, mbuddy32;
   logic [FW-1:0] head_sel, head_t, init_nxt, init_prv;

   assign rd_code = rd_ff[WW-1 -: OW];
   assign rd_free = rd_ff[2*FW];
   assign rd_next = rd_ff[2*FW-1:FW];
   assign rd_prev = rd_ff[FW-1:0];

   assign idx32    = 32'(idx_ff);
   assign cur32    = 32'(cur_ff);
   assign init_f32 = 32'(initf_ff);
   assign size32   = 32'd1 << inito_ff;
   assign mask32   = size32 - 32'd1;
   assign end32    = FRAMES_U & ~mask32;
   assign start32  = (inito_ff == MAXO) ? 32'd0 : (FRAMES_U & ~((size32 << 1) - 32'd1));
   assign init_nxt = ((init_f32 + size32) < end32) ? FW'(init_f32 + size32) : NONE;
   assign init_prv = (init_f32 == start32) ? NONE : FW'(init_f32 - size32);
   assign head_sel = (src_ff <= MAXO) ? head_ff[src_ff[HW-1:0]] : NONE;
   assign head_t   = head_ff[tord_ff[HW-1:0]];
   assign sbuddy32 = cur32 ^ (32'd1 << (src_ff - OW'(1)));
   assign mbuddy32 = cur32 ^ (32'd1 << val_ff);

   always_comb begin
      stat.init_done    = (initf_ff == NONE);
      stat.op           = op_ff;
      stat.want_done    = (sh_ff == 32'd0) || (want_ff > MAXO);
      stat.want_over    = (want_ff > MAXO);
      stat.src_done     = (src_ff > MAXO) || (head_sel != NONE);
      stat.src_over     = (src_ff > MAXO);
      stat.idx_oor      = (idx32 >= FRAMES_U);
      stat.rd_free      = rd_free;
      stat.rd_code_big  = (rd_code > MAXO);
      stat.rd_prev_none = (rd_prev == NONE);
      stat.rd_next_none = (rd_next == NONE);
      stat.ul_next_none = (uln_ff == NONE);
      stat.split_more   = (src_ff > want_ff);
      stat.buddy_in     = (sbuddy32 < FRAMES_U);
      stat.push_h_none  = (head_t == NONE);
      stat.mrg_stop     = (val_ff >= MAXO) || (mbuddy32 >= FRAMES_U);
      stat.mrg_ok       = rd_free && (rd_code == val_ff);
      stat.out_busy     = rspv_ff && !rsp_ready;
   end

   always_comb begin
      op_in = op_ff;  sh_in = sh_ff;  idx_in = idx_ff;  want_in = want_ff;
      src_in = src_ff;  val_in = val_ff;  cur_in = cur_ff;  tgt_in = tgt_ff;
      tord_in = tord_ff;  h_in = h_ff;  ulc_in = ulc_ff;  ulp_in = ulp_ff;
      uln_in = uln_ff;  head_in = head_ff;  initf_in = initf_ff;  inito_in = inito_ff;
      resf_in = resf_ff;  reso_in = reso_ff;  ress_in = ress_ff;
      rspf_in = rspf_ff;  rspo_in = rspo_ff;  rsps_in = rsps_ff;
      rspv_in = rspv_ff && !rsp_ready;
      mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = '0;  mem_wdata = '0;
      case (cmd)
         CMD_INIT_STEP: begin
            if (init_f32 >= end32) begin
               inito_in = inito_ff - OW'(1);
            end else begin
               mem_we   = 1'b1;
               mem_addr = initf_ff[AW-1:0];
               if ((init_f32 & mask32) == 32'd0) begin
                  mem_wdata = {inito_ff, 1'b1, init_nxt, init_prv};
                  if (init_f32 == start32) head_in[inito_ff[HW-1:0]] = initf_ff;
               end else begin
                  mem_wdata = {INTERIOR, 1'b0, NONE, NONE};
               end
               initf_in = initf_ff + FW'(1);
            end
         end
         CMD_LOAD: begin
            op_in   = req_op;
            idx_in  = req_free_frame;
            sh_in   = (req_bytes == 32'd0) ? 32'd0 : ((req_bytes - 32'd1) >> PAGE_SHIFT);
            want_in = '0;
         end
         CMD_WANT_STEP: begin
            if (!stat.want_done) begin
               want_in = want_ff + OW'(1);
               sh_in   = sh_ff >> 1;
            end else begin
               src_in = want_ff;
            end
         end
         CMD_SRC_STEP: begin
            if (!stat.src_done) begin
               src_in = src_ff + OW'(1);
            end else begin
               cur_in = head_sel[AW-1:0];
               tgt_in = head_sel[AW-1:0];
            end
         end
         CMD_RD_TGT: begin
            mem_re = 1'b1;  mem_addr = tgt_ff;
         end
         CMD_UL_CAP: begin
            ulc_in = rd_code;  ulp_in = rd_prev;  uln_in = rd_next;
            if (rd_code <= MAXO && rd_prev == NONE) head_in[rd_code[HW-1:0]] = rd_next;
         end
         CMD_UL_PRD: begin
            mem_re = 1'b1;  mem_addr = ulp_ff[AW-1:0];
         end
         CMD_UL_PWR: begin
            mem_we = 1'b1;  mem_addr = ulp_ff[AW-1:0];
            mem_wdata = {rd_code, rd_free, uln_ff, rd_prev};
         end
         CMD_UL_NRD: begin
            mem_re = 1'b1;  mem_addr = uln_ff[AW-1:0];
         end
         CMD_UL_NWR: begin
            mem_we = 1'b1;  mem_addr = uln_ff[AW-1:0];
            mem_wdata = {rd_code, rd_free, rd_next, ulp_ff};
         end
         CMD_UL_FWR: begin
            mem_we = 1'b1;  mem_addr = tgt_ff;
            mem_wdata = {(op_ff ? INTERIOR : ulc_ff), 1'b0, NONE, NONE};
            if (op_ff) begin
               // merged: keep the lower of the two buddies, one order up
               cur_in = (tgt_ff < cur_ff) ? tgt_ff : cur_ff;
               val_in = val_ff + OW'(1);
            end
         end
         CMD_SPLIT: begin
            tgt_in  = sbuddy32[AW-1:0];
            tord_in = src_ff - OW'(1);
            src_in  = src_ff - OW'(1);
         end
         CMD_PUSH_F: begin
            mem_we = 1'b1;  mem_addr = tgt_ff;
            mem_wdata = {tord_ff, 1'b1, head_t, NONE};
            h_in = head_t;
            head_in[tord_ff[HW-1:0]] = FW'(tgt_ff);
            resf_in = 12'(tgt_ff);  reso_in = 4'(tord_ff);  ress_in = ST_FREED;
         end
         CMD_PUSH_HRD: begin
            mem_re = 1'b1;  mem_addr = h_ff[AW-1:0];
         end
         CMD_PUSH_HWR: begin
            mem_we = 1'b1;  mem_addr = h_ff[AW-1:0];
            mem_wdata = {rd_code, rd_free, rd_next, FW'(tgt_ff)};
         end
         CMD_FIX_RD: begin
            mem_re = 1'b1;  mem_addr = cur_ff;
         end
         CMD_FIX_WR: begin
            mem_we = 1'b1;  mem_addr = cur_ff;
            mem_wdata = {want_ff, rd_free, rd_next, rd_prev};
            resf_in = 12'(cur_ff);  reso_in = 4'(want_ff);  ress_in = ST_ALLOC;
         end
         CMD_FREE_RD: begin
            mem_re = 1'b1;  mem_addr = idx32[AW-1:0];
            cur_in = idx32[AW-1:0];
         end
         CMD_FREE_MARK: begin
            mem_we = 1'b1;  mem_addr = cur_ff;
            mem_wdata = {INTERIOR, rd_free, rd_next, rd_prev};
            val_in = (rd_code > MAXO) ? '0 : rd_code;
         end
         CMD_MRG_RD: begin
            if (stat.mrg_stop) begin
               tgt_in = cur_ff;  tord_in = val_ff;
            end else begin
               mem_re = 1'b1;  mem_addr = mbuddy32[AW-1:0];
               tgt_in = mbuddy32[AW-1:0];
            end
         end
         CMD_MRG_END: begin
            tgt_in = cur_ff;  tord_in = val_ff;
         end
         CMD_RES_OVER: begin
            resf_in = '0;  reso_in = '0;  ress_in = ST_BIG;
         end
         CMD_RES_EMPTY: begin
            resf_in = '0;  reso_in = 4'(want_ff);  ress_in = ST_EMPTY;
         end
         CMD_RES_OOR: begin
            resf_in = idx_ff;  reso_in = '0;  ress_in = ST_FREED;
         end
         CMD_RES_DBL: begin
            resf_in = idx_ff;  reso_in = 4'(rd_code);  ress_in = ST_FREED;
         end
         CMD_OUT: begin
            rspv_in = 1'b1;
            rspf_in = resf_ff;  rspo_in = reso_ff;  rsps_in = ress_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_ff <= frame_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  sh_ff <= sh_in;  idx_ff <= idx_in;  want_ff <= want_in;
      src_ff <= src_in;  val_ff <= val_in;  cur_ff <= cur_in;  tgt_ff <= tgt_in;
      tord_ff <= tord_in;  h_ff <= h_in;  ulc_ff <= ulc_in;  ulp_ff <= ulp_in;
      uln_ff <= uln_in;  resf_ff <= resf_in;  reso_ff <= reso_in;  ress_ff <= ress_in;
      rspf_ff <= rspf_in;  rspo_ff <= rspo_in;  rsps_ff <= rsps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initf_ff <= '0;
         inito_ff <= MAXO;
         rspv_ff  <= 1'b0;
         for (int i = 0; i <= MAX_ORDER_LEVEL; i++) head_ff[i] <= NONE;
      end else begin
         initf_ff <= initf_in;
         inito_ff <= inito_in;
         rspv_ff  <= rspv_in;
         head_ff  <= head_in;
      end
   end

   assign rsp_valid       = rspv_ff;
   assign rsp_frame_index = rspf_ff;
   assign rsp_block_order = rspo_ff;
   assign rsp_status      = rsps_ff;

endmodule

### rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: issues one datapath command per cycle.
`timescale 1ns / 1ps
module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bpa_pkg::stat_type stat,
   output bpa_pkg::cmd_type  cmd
);
   import bpa_pkg::*;

   localparam logic [4:0] S_INIT     = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_WANT     = 5'd2;
   localparam logic [4:0] S_SRC      = 5'd3;
   localparam logic [4:0] S_UL_RD    = 5'd4;
   localparam logic [4:0] S_UL_CAP   = 5'd5;
   localparam logic [4:0] S_UL_PRD   = 5'd6;
   localparam logic [4:0] S_UL_PWR   = 5'd7;
   localparam logic [4:0] S_UL_NRD   = 5'd8;
   localparam logic [4:0] S_UL_NWR   = 5'd9;
   localparam logic [4:0] S_UL_FWR   = 5'd10;
   localparam logic [4:0] S_SPLIT    = 5'd11;
   localparam logic [4:0] S_PUSH_F   = 5'd12;
   localparam logic [4:0] S_PUSH_HRD = 5'd13;
   localparam logic [4:0] S_PUSH_HWR = 5'd14;
   localparam logic [4:0] S_FIX_WR   = 5'd15;
   localparam logic [4:0] S_FREE_CHK = 5'd16;
   localparam logic [4:0] S_MRG_RD   = 5'd17;
   localparam logic [4:0] S_MRG_CHK  = 5'd18;
   localparam logic [4:0] S_OUT      = 5'd19;

   logic [4:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NOP;
      case (state_ff)
         S_INIT: begin
            if (stat.init_done) state_in = S_IDLE;
            else cmd = CMD_INIT_STEP;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd = CMD_LOAD;
               state_in = S_WANT;
            end
         end
         S_WANT: begin
            if (stat.op) begin
               if (stat.idx_oor) begin
                  cmd = CMD_RES_OOR;  state_in = S_OUT;
               end else begin
                  cmd = CMD_FREE_RD;  state_in = S_FREE_CHK;
               end
            end else if (stat.want_done && stat.want_over) begin
               cmd = CMD_RES_OVER;  state_in = S_OUT;
            end else begin
               cmd = CMD_WANT_STEP;
               if (stat.want_done) state_in = S_SRC;
            end
         end
         S_SRC: begin
            if (stat.src_done && stat.src_over) begin
               cmd = CMD_RES_EMPTY;  state_in = S_OUT;
            end else begin
               cmd = CMD_SRC_STEP;
               if (stat.src_done) state_in = S_UL_RD;
            end
         end
         S_UL_RD: begin
            cmd = CMD_RD_TGT;  state_in = S_UL_CAP;
         end
         S_UL_CAP: begin
            cmd = CMD_UL_CAP;
            if (stat.rd_code_big) state_in = S_SPLIT;
            else if (!stat.rd_prev_none) state_in = S_UL_PRD;
            else if (!stat.rd_next_none) state_in = S_UL_NRD;
            else state_in = S_UL_FWR;
         end
         S_UL_PRD: begin
            cmd = CMD_UL_PRD;  state_in = S_UL_PWR;
         end
         S_UL_PWR: begin
            cmd = CMD_UL_PWR;
            state_in = stat.ul_next_none ? S_UL_FWR : S_UL_NRD;
         end
         S_UL_NRD: begin
            cmd = CMD_UL_NRD;  state_in = S_UL_NWR;
         end
         S_UL_NWR: begin
            cmd = CMD_UL_NWR;  state_in = S_UL_FWR;
         end
         S_UL_FWR: begin
            cmd = CMD_UL_FWR;
            state_in = stat.op ? S_MRG_RD : S_SPLIT;
         end
         S_SPLIT: begin
            if (stat.split_more) begin
               cmd = CMD_SPLIT;
               if (stat.buddy_in) state_in = S_PUSH_F;
            end else begin
               cmd = CMD_FIX_RD;  state_in = S_FIX_WR;
            end
         end
         S_PUSH_F: begin
            cmd = CMD_PUSH_F;
            if (!stat.push_h_none) state_in = S_PUSH_HRD;
            else state_in = stat.op ? S_OUT : S_SPLIT;
         end
         S_PUSH_HRD: begin
            cmd = CMD_PUSH_HRD;  state_in = S_PUSH_HWR;
         end
         S_PUSH_HWR: begin
            cmd = CMD_PUSH_HWR;
            state_in = stat.op ? S_OUT : S_SPLIT;
         end
         S_FIX_WR: begin
            cmd = CMD_FIX_WR;  state_in = S_OUT;
         end
         S_FREE_CHK: begin
            if (stat.rd_free) begin
               cmd = CMD_RES_DBL;  state_in = S_OUT;
            end else begin
               cmd = CMD_FREE_MARK;  state_in = S_MRG_RD;
            end
         end
         S_MRG_RD: begin
            cmd = CMD_MRG_RD;
            state_in = stat.mrg_stop ? S_PUSH_F : S_MRG_CHK;
         end
         S_MRG_CHK: begin
            if (stat.mrg_ok) begin
               state_in = S_UL_CAP;
            end else begin
               cmd = CMD_MRG_END;  state_in = S_PUSH_F;
            end
         end
         S_OUT: begin
            if (!stat.out_busy) begin
               cmd = CMD_OUT;  state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else state_ff <= state_in;
   end

endmodule

### rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator.
`timescale 1ns / 1ps
// Buddy page allocator over FRAMES page frames with LIFO free lists per order
// (0..MAX_ORDER_LEVEL). Each request item is an allocate (tuser 0: byte count
// rounded up to 2^order pages of 2^PAGE_SHIFT bytes) or a free (tuser 1:
// first frame of the block); each gives exactly one response item with the
// frame, the order and a status (0 allocated, 1 freed, 2 no free block,
// 3 request too large). After reset a layout pass writes one frame per cycle
// (apart from steps down an order) and stalls requests until it is done. Items
// are handled one at a time by a sequencer around a single-port frame memory
// (one read or write per cycle, registered read). An allocate sizes the order,
// finds a non-empty list, unlinks its head block, splits it down pushing each
// buddy in range, and writes the final order; a free checks and marks the frame,
// merges with each free buddy of equal order and pushes the result. The next
// request is taken while a response still waits in the output register.
module buddy_page_allocator #(
   parameter int FRAMES          = bpa_pkg::FRAMES_DEF,
   parameter int MAX_ORDER_LEVEL = bpa_pkg::MAX_ORDER_LEVEL_DEF,
   parameter int PAGE_SHIFT      = bpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [31:0] request_bytes, [43:32] free_frame, rest zero
   input  logic        req_tuser,  // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [11:0] frame_index, [15:12] block_order
   output logic [1:0]  rsp_tuser   // [1:0] status
);
   import bpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpa_datapath #(
      .FRAMES          (FRAMES),
      .MAX_ORDER_LEVEL (MAX_ORDER_LEVEL),
      .PAGE_SHIFT      (PAGE_SHIFT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_tuser),
      .req_bytes       (req_tdata[31:0]),
      .req_free_frame  (req_tdata[43:32]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_frame_index (rsp_tdata[11:0]),
      .rsp_block_order (rsp_tdata[15:12]),
      .rsp_status      (rsp_tuser)
   );

endmodule

### test/buddy_page_allocator_tb.sv
// Self-checking buddy page allocator bench: directed and random allocate/free traffic.
`timescale 1ns / 1ps
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int NFR      = FRAMES_DEF;
   localparam int MAXO     = MAX_ORDER_LEVEL_DEF;
   localparam int PSHIFT   = PAGE_SHIFT_DEF;
   localparam int NIL      = NFR;
   localparam int INTERIOR = MAXO + 1;
   localparam int N_RANDOM = 1500;
   localparam int STALL_LIMIT = 20000;
   localparam bit OP_ALLOC = 1'b0;
   localparam bit OP_FREE  = 1'b1;

   typedef struct {
      bit          op;
      logic [31:0] bytes;
      logic [11:0] frame;
   } req_item_type;

   typedef struct {
      logic [11:0] frame;
      logic [3:0]  order;
      logic [1:0]  status;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   always #1 clock = ~clock;

   buddy_page_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // shadow allocator state
   int          blk_order [NFR];
   bit          blk_free [NFR];
   int          link_nxt [NFR];
   int          link_prv [NFR];
   int          free_head [MAXO + 1];

   req_item_type pending_reqs [$];
   rsp_item_type expected_rsps [$];
   int          live_blocks [$];
   req_item_type cur_req;
   int          n_queued = 0;
   int          n_accepted = 0;
   int          n_returned = 0;
   int          errors = 0;

   function automatic void layout_reset();
      int start;
      int tail;
      int cnt;
      start = 0;
      for (int o = 0; o <= MAXO; o++) free_head[o] = NIL;
      for (int f = 0; f < NFR; f++) begin
         blk_order[f] = INTERIOR;
         blk_free[f]  = 0;
         link_nxt[f]  = NIL;
         link_prv[f]  = NIL;
      end
      for (int o = MAXO; o >= 0; o--) begin
         cnt  = (NFR - start) >> o;
         tail = NIL;
         for (int i = 0; i < cnt; i++) begin
            int f;
            f = start + (i << o);
            blk_order[f] = o;
            blk_free[f]  = 1;
            link_prv[f]  = tail;
            if (tail == NIL) free_head[o] = f;
            else link_nxt[tail] = f;
            tail = f;
         end
         start += cnt << o;
      end
   endfunction

   function automatic void list_push(int f, int o);
      int h;
      h = free_head[o];
      blk_order[f] = o;
      link_prv[f]  = NIL;
      link_nxt[f]  = h;
      if (h != NIL) link_prv[h] = f;
      free_head[o] = f;
      blk_free[f]  = 1;
   endfunction

   function automatic void list_unlink(int f);
      int o;
      int p;
      int n;
      o = blk_order[f];
      p = link_prv[f];
      n = link_nxt[f];
      if (o > MAXO) return;
      if (p == NIL) free_head[o] = n;
      else link_nxt[p] = n;
      if (n != NIL) link_prv[n] = p;
      link_nxt[f] = NIL;
      link_prv[f] = NIL;
      blk_free[f] = 0;
   endfunction

   // Works out the response of one accepted request and updates the shadow state.
   function automatic rsp_item_type allocate_or_free(req_item_type r);
      rsp_item_type res;
      int want;
      int src;
      int cur;
      int val;
      int bud;
      res = '{frame: '0, order: '0, status: ST_FREED};
      if (r.op == OP_ALLOC) begin
         want = 0;
         while (want <= MAXO && (longint'(1) << (want + PSHIFT)) < longint'(r.bytes))
            want++;
         if (want > MAXO) begin
            res.status = ST_BIG;
         end else begin
            src = want;
            while (src <= MAXO && free_head[src] == NIL) src++;
            if (src > MAXO) begin
               res.status = ST_EMPTY;
               res.order  = 4'(want);
            end else begin
               cur = free_head[src];
               list_unlink(cur);
               for (int j = src; j > want; j--) begin
                  bud = cur ^ (1 << (j - 1));
                  if (bud < NFR) list_push(bud, j - 1);
               end
               blk_order[cur] = want;
               res = '{frame: 12'(cur), order: 4'(want), status: ST_ALLOC};
               live_blocks.push_back(cur);
            end
         end
      end else if (blk_free[r.frame]) begin
         // double free: report the existing block, no change
         res.frame = r.frame;
         res.order = 4'(blk_order[r.frame]);
      end else begin
         cur = int'(r.frame);
         val = blk_order[cur];
         if (val > MAXO) val = 0;   // interior frame acts as an order-0 block
         blk_order[cur] = INTERIOR;
         while (val < MAXO) begin
            bud = cur ^ (1 << val);
            if (bud >= NFR || !blk_free[bud] || blk_order[bud] != val) break;
            list_unlink(bud);
            blk_order[bud] = INTERIOR;
            blk_order[cur] = INTERIOR;
            if (bud < cur) cur = bud;
            val++;
         end
         list_push(cur, val);
         res.frame = 12'(cur);
         res.order = 4'(val);
      end
      return res;
   endfunction

   // ---------------- request driver ----------------
   int burst_left = 0;
   int gap_left = 0;
   bit req_done = 1'b0;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(allocate_or_free(cur_req));
         n_accepted++;
         req_done = 1'b1;
      end
   end

   // a new item goes out only once the offered one has been taken
   always @(negedge clock) begin
      bit drive;
      if (!reset && (!req_tvalid || req_done)) begin
         req_done = 1'b0;
         drive = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            drive = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = int'($urandom_range(0, 12));
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6));
            end
         end
         req_tvalid <= drive;
         req_tuser  <= drive ? cur_req.op : 1'b0;
         req_tdata  <= drive ? {4'b0, cur_req.frame, cur_req.bytes} : '0;
      end
   end

   // ---------------- response monitor ----------------
   int rx_phase = 0;
   int rx_mode = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_returned++;
         if (expected_rsps.size() == 0) begin
            $error("response item with nothing expected: %h/%h", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[11:0] !== e.frame) begin
               $error("frame_index expected %0d actual %0d", e.frame, rsp_tdata[11:0]);
               errors++;
            end
            if (rsp_tdata[15:12] !== e.order) begin
               $error("block_order expected %0d actual %0d", e.order, rsp_tdata[15:12]);
               errors++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Stall pattern: always ready, coin flip, or mostly stalled, in modes picked at
   // random; once, a long hold-off while requests keep coming.
   always @(negedge clock) begin
      bit rdy;
      rx_phase++;
      if (rx_phase % 64 == 0) rx_mode = int'($urandom_range(0, 2));
      if (!hold_done && n_accepted == 300) begin
         hold_done = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else begin
         case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            default: rdy = ($urandom_range(0, 3) == 0);
         endcase
      end
      rsp_tready <= rdy;
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic queue_alloc(logic [31:0] b);
      pending_reqs.push_back('{op: OP_ALLOC, bytes: b, frame: 12'($urandom)});
      n_queued++;
   endtask

   task automatic queue_free(logic [11:0] f);
      pending_reqs.push_back('{op: OP_FREE, bytes: $urandom, frame: f});
      n_queued++;
   endtask

   // wait until every queued item has been taken by the block
   task automatic settle();
      while (n_accepted != n_queued) @(negedge clock);
   endtask

   task automatic free_live();
      int k;
      k = int'($urandom_range(0, live_blocks.size() - 1));
      queue_free(12'(live_blocks[k]));
      live_blocks.delete(k);
   endtask

   initial begin
      int k;
      layout_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: size extremes, oversized, zero bytes
      queue_alloc(32'd0);
      queue_alloc(32'd1);
      queue_alloc(32'd4096);
      queue_alloc(32'd4097);
      queue_alloc(32'h0040_0000);
      queue_alloc(32'h0040_0001);
      queue_alloc(32'hFFFF_FFFF);
      queue_alloc(32'h8000_0000);
      settle();
      // double free of a free block start, free of an interior frame
      queue_free(12'd3072);
      queue_free(12'd4095);
      while (live_blocks.size() > 0) free_live();
      settle();
      // exhaust memory with largest blocks, then give them back
      repeat (6) queue_alloc(32'h0040_0000);
      settle();
      while (live_blocks.size() > 0) free_live();
      queue_free(12'hFFF);
      settle();

      for (int i = 0; i < N_RANDOM; i++) begin
         while (pending_reqs.size() > 3) @(negedge clock);
         k = int'($urandom_range(0, 99));
         if (k < 4) begin
            queue_alloc($urandom);                          // mostly oversized
         end else if (k < 7) begin
            queue_free(12'($urandom));                      // stray free
         end else if (k < 50 && live_blocks.size() > 0) begin
            free_live();
         end else begin
            int o;
            o = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAXO))
                                            : int'($urandom_range(0, 3));
            queue_alloc($urandom_range(0, 1 << (PSHIFT + o)));
         end
      end
      while (live_blocks.size() > 0) begin
         while (pending_reqs.size() > 3) @(negedge clock);
         free_live();
      end
      settle();
      while (expected_rsps.size() > 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
